FILE: rtl/mi3_pkg.sv
// Types, constants and operand tables shared by the 3x3 adjugate inverse block.
package mi3_pkg;

	localparam int EW = 16;
	localparam int FB = 8;
	localparam int OW = 32;
	localparam int QB = OW - 1;
	localparam int TW = 48;
	localparam int DAW = 64;
	localparam int AW = 4;

	localparam int PW = 2 * EW;
	localparam int CW = 2 * EW + 1;
	localparam int DPW = EW + CW;
	localparam int DW = 3 * EW + 3;
	localparam int NW = CW + 3 * FB;
	localparam int RW = DW;
	localparam int CMPW = (DW > TW) ? DW : TW;
	localparam int SW = (NW > DW + QB) ? NW : DW + QB;

	localparam int NL = 9;
	localparam int COF_ST = 5;
	localparam int LANE_ST = QB + 1;
	localparam int TOT_ST = COF_ST + LANE_ST;

	localparam logic REG_THRESH = 1'b0;
	localparam logic [TW-1:0] THRESH_RST = TW'(1);

	localparam logic signed [OW-1:0] SAT_MAX = {1'b0, {QB{1'b1}}};
	localparam logic signed [OW-1:0] SAT_MIN = {1'b1, {QB{1'b0}}};

	// cofactor k = e[op0]*e[op1] - e[op2]*e[op3], negated where CF_NEG is set
	localparam int CF_OP [NL][4] = '{
		'{4, 8, 5, 7}, '{3, 8, 5, 6}, '{3, 7, 4, 6},
		'{1, 8, 2, 7}, '{0, 8, 2, 6}, '{0, 7, 1, 6},
		'{1, 5, 2, 4}, '{0, 5, 2, 3}, '{0, 4, 1, 3}
	};
	localparam logic [NL-1:0] CF_NEG = 9'b010101010;

	typedef struct packed {
		logic signed [EW-1:0] a_r0c0;
		logic signed [EW-1:0] a_r0c1;
		logic signed [EW-1:0] a_r0c2;
		logic signed [EW-1:0] a_r1c0;
		logic signed [EW-1:0] a_r1c1;
		logic signed [EW-1:0] a_r1c2;
		logic signed [EW-1:0] a_r2c0;
		logic signed [EW-1:0] a_r2c1;
		logic signed [EW-1:0] a_r2c2;
	} in_t;

	typedef struct packed {
		logic signed [OW-1:0] inv_r0c0;
		logic signed [OW-1:0] inv_r0c1;
		logic signed [OW-1:0] inv_r0c2;
		logic signed [OW-1:0] inv_r1c0;
		logic signed [OW-1:0] inv_r1c1;
		logic signed [OW-1:0] inv_r1c2;
		logic signed [OW-1:0] inv_r2c0;
		logic signed [OW-1:0] inv_r2c1;
		logic signed [OW-1:0] inv_r2c2;
		logic                 singular;
	} out_t;

	typedef struct packed {
		logic                     sing;
		logic [NL-1:0]            neg;
		logic [DW-1:0]            den;
		logic [NL-1:0][NW-1:0]    num;
	} cof_t;

endpackage

FILE: rtl/matrix_inverse_3x3.sv
// Top level: 3x3 matrix inverse by adjugate, nine divider lanes, merge and skid output.
//
// Input channel in_valid/in_ready/in_data carries one matrix word of nine signed
// Q8.8 elements. Output channel out_valid/out_ready/out_data carries nine signed
// Q16.16 inverse elements and the singular flag; singular words carry zeros.
// The APB port holds singular_threshold at byte address 0 (64-bit data, reset 1).
// Throughput: one word per cycle while no word waits in the skid register. An
// accepted word loads the first of five front-end stages (products,
// cofactors, determinant terms, determinant, magnitude compare); then come 32
// divider stages (one saturation check plus 31 quotient bits of the restoring
// divide) and one output register. All of these stages together set the latency.
// Reset clears all valid flags and loads the threshold with 1; no clearing pass.
// When out_ready is low, one further word lands in a skid register; after that
// in_ready drops and the whole pipeline holds until the output drains.
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [AW-1:0]  paddr,
	input  logic [DAW-1:0] pwdata,
	output logic [DAW-1:0] prdata,
	output logic           pready,
	input  logic           in_valid,
	output logic           in_ready,
	input  in_t            in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output out_t           out_data
);

	logic                 adv;
	logic [TW-1:0]        thresh_q;
	logic                 v_s [0:TOT_ST-1];
	logic                 sing_s [0:QB];
	cof_t                 cof_s5;
	logic signed [OW-1:0] quo [NL];
	logic signed [OW-1:0] mq [NL];
	out_t                 tail;
	out_t                 skid_q;
	logic                 skid_v_q;
	out_t                 out_q;
	logic                 out_v_q;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_THRESH) ? DAW'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
		end else if (psel && penable && pwrite && paddr[3] == REG_THRESH) begin
			thresh_q <= pwdata[TW-1:0];
		end
	end

	assign adv = !skid_v_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TOT_ST; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < TOT_ST; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	mi3_cof u_cof (
		.clk    (clk),
		.en     (adv),
		.a      (in_data),
		.thresh (thresh_q),
		.res_s5 (cof_s5)
	);

	for (genvar k = 0; k < NL; k++) begin : g_lane
		mi3_div_lane u_lane (
			.clk (clk),
			.en  (adv),
			.num (cof_s5.num[k]),
			.den (cof_s5.den),
			.neg (cof_s5.neg[k]),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s[0] <= cof_s5.sing;
			for (int k = 1; k <= QB; k++) begin
				sing_s[k] <= sing_s[k-1];
			end
		end
	end

	// merge lanes; singular words are forced to zero
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			mq[k] = sing_s[QB] ? '0 : quo[k];
		end
		tail.inv_r0c0 = mq[0];
		tail.inv_r0c1 = mq[1];
		tail.inv_r0c2 = mq[2];
		tail.inv_r1c0 = mq[3];
		tail.inv_r1c1 = mq[4];
		tail.inv_r1c2 = mq[5];
		tail.inv_r2c0 = mq[6];
		tail.inv_r2c1 = mq[7];
		tail.inv_r2c2 = mq[8];
		tail.singular = sing_s[QB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q || v_s[TOT_ST-1];
			skid_v_q <= 1'b0;
		end else if (v_s[TOT_ST-1] && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : tail;
		end else if (v_s[TOT_ST-1] && !skid_v_q) begin
			skid_q <= tail;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held with empty output register");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !out_ready) |=> skid_v_q)
		else $error("skid word lost while output stalled");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.singular) |-> (out_q.inv_r0c0 == '0 && out_q.inv_r1c1 == '0
			&& out_q.inv_r2c2 == '0 && out_q.inv_r0c2 == '0 && out_q.inv_r2c0 == '0))
		else $error("singular word with nonzero inverse");

	a_tail_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && v_s[TOT_ST-1]) |=> (v_s[TOT_ST-1] || !skid_v_q))
		else $error("pipeline tail dropped during stall");

endmodule

FILE: rtl/mi3_cof.sv
// Cofactor, determinant and singularity front end: five pipeline stages.
module mi3_cof import mi3_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  in_t           a,
	input  logic [TW-1:0] thresh,
	output cof_t          res_s5
);

	logic signed [EW-1:0]  e [NL];
	logic signed [PW-1:0]  prod1_s1 [NL];
	logic signed [PW-1:0]  prod2_s1 [NL];
	logic signed [EW-1:0]  row0_s1 [3];
	logic signed [CW-1:0]  cof_s2 [NL];
	logic signed [EW-1:0]  row0_s2 [3];
	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [CW-1:0]  cof_s3 [NL];
	logic signed [DW-1:0]  det_s4;
	logic [CW-1:0]         mag_s4 [NL];
	logic [NL-1:0]         asgn_s4;
	logic [DW-1:0]         dmag;

	assign e[0] = a.a_r0c0;
	assign e[1] = a.a_r0c1;
	assign e[2] = a.a_r0c2;
	assign e[3] = a.a_r1c0;
	assign e[4] = a.a_r1c1;
	assign e[5] = a.a_r1c2;
	assign e[6] = a.a_r2c0;
	assign e[7] = a.a_r2c1;
	assign e[8] = a.a_r2c2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				prod1_s1[k] <= e[CF_OP[k][0]] * e[CF_OP[k][1]];
				prod2_s1[k] <= e[CF_OP[k][2]] * e[CF_OP[k][3]];
			end
			for (int j = 0; j < 3; j++) begin
				row0_s1[j] <= e[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				if (CF_NEG[k]) begin
					cof_s2[k] <= CW'(prod2_s1[k]) - CW'(prod1_s1[k]);
				end else begin
					cof_s2[k] <= CW'(prod1_s1[k]) - CW'(prod2_s1[k]);
				end
			end
			row0_s2 <= row0_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dp_s3[j] <= row0_s2[j] * cof_s2[j];
			end
			cof_s3 <= cof_s2;
		end
	end

	// adjugate element (i,j) is cofactor (j,i)
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= DW'(dp_s3[0]) + DW'(dp_s3[1]) + DW'(dp_s3[2]);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					asgn_s4[i*3+j] <= cof_s3[j*3+i][CW-1];
					if (cof_s3[j*3+i][CW-1]) begin
						mag_s4[i*3+j] <= CW'(-cof_s3[j*3+i]);
					end else begin
						mag_s4[i*3+j] <= CW'(cof_s3[j*3+i]);
					end
				end
			end
		end
	end

	assign dmag = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.sing <= (dmag == '0) || (CMPW'(dmag) < CMPW'(thresh));
			res_s5.den  <= dmag;
			res_s5.neg  <= asgn_s4 ^ {NL{det_s4[DW-1]}};
			for (int k = 0; k < NL; k++) begin
				res_s5.num[k] <= {mag_s4[k], {(3 * FB){1'b0}}};
			end
		end
	end

endmodule

FILE: rtl/mi3_div_lane.sv
// One divider lane: saturation check and a restoring divide, one quotient bit per stage.
module mi3_div_lane import mi3_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	input  logic                 neg,
	output logic signed [OW-1:0] quo
);

	logic [RW-1:0] rem_s [0:QB];
	logic [QB-1:0] low_s [0:QB];
	logic [QB-1:0] qt_s  [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic          sat_s [0:QB];
	logic          neg_s [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= SW'(num) >= (SW'(den) << QB);
			rem_s[0] <= RW'(num >> QB);
			low_s[0] <= num[QB-1:0];
			qt_s[0]  <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [RW:0] t;
		logic        ge;

		always_comb begin
			t  = {rem_s[k-1], low_s[k-1][QB-k]};
			ge = t >= {1'b0, den_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RW'(t - {1'b0, den_s[k-1]}) : RW'(t);
				qt_s[k]  <= {qt_s[k-1][QB-2:0], ge};
				low_s[k] <= low_s[k-1];
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	always_comb begin
		if (sat_s[QB]) begin
			quo = neg_s[QB] ? SAT_MIN : SAT_MAX;
		end else if (neg_s[QB]) begin
			quo = -$signed({1'b0, qt_s[QB]});
		end else begin
			quo = $signed({1'b0, qt_s[QB]});
		end
	end

endmodule

FILE: bench/matrix_inverse_3x3_tb.sv
// Testbench for matrix_inverse_3x3: directed and random matrices checked against a fixed-point predictor.
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb;
	import mi3_pkg::*;

	localparam int LATENCY = 38;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [AW-1:0] ADDR_THRESH = AW'(0);
	localparam logic [AW-1:0] ADDR_UNUSED = AW'(8);

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [DAW-1:0] pwdata;
	logic [DAW-1:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	in_t in_data;
	logic out_valid, out_ready;
	out_t out_data;

	logic [TW-1:0] threshold;
	out_t inverse_queue[$];
	int errors;
	int words_sent;
	int words_checked;
	int singular_seen;
	int saturated_seen;
	int idle_cycles;
	bit timed_out;

	matrix_inverse_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] divide_lane(logic signed [63:0] adj, logic signed [63:0] det);
		logic [63:0] dmag, amag, q;
		logic neg;
		dmag = det[63] ? -det : det;
		amag = adj[63] ? -adj : adj;
		neg = adj[63] != det[63];
		q = (amag << (3 * FB)) / dmag;
		if (neg)
			return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
	endfunction

	function automatic out_t predict_inverse(in_t m);
		logic signed [63:0] a[3][3];
		logic signed [63:0] c[3][3];
		logic signed [63:0] det;
		logic [63:0] dmag;
		logic [31:0] r[9];
		out_t o;
		a[0][0] = m.a_r0c0; a[0][1] = m.a_r0c1; a[0][2] = m.a_r0c2;
		a[1][0] = m.a_r1c0; a[1][1] = m.a_r1c1; a[1][2] = m.a_r1c2;
		a[2][0] = m.a_r2c0; a[2][1] = m.a_r2c1; a[2][2] = m.a_r2c2;
		c[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
		c[0][1] = -(a[1][0] * a[2][2] - a[1][2] * a[2][0]);
		c[0][2] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
		c[1][0] = -(a[0][1] * a[2][2] - a[0][2] * a[2][1]);
		c[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
		c[1][2] = -(a[0][0] * a[2][1] - a[0][1] * a[2][0]);
		c[2][0] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
		c[2][1] = -(a[0][0] * a[1][2] - a[0][2] * a[1][0]);
		c[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
		det = a[0][0] * c[0][0] + a[0][1] * c[0][1] + a[0][2] * c[0][2];
		dmag = det[63] ? -det : det;
		o = '0;
		if (dmag == 0 || dmag < {16'b0, threshold}) begin
			o.singular = 1'b1;
			return o;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i * 3 + j] = divide_lane(c[j][i], det);
		o.inv_r0c0 = r[0]; o.inv_r0c1 = r[1]; o.inv_r0c2 = r[2];
		o.inv_r1c0 = r[3]; o.inv_r1c1 = r[4]; o.inv_r1c2 = r[5];
		o.inv_r2c0 = r[6]; o.inv_r2c1 = r[7]; o.inv_r2c2 = r[8];
		return o;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// output checker and receiver stall pattern
	initial begin
		out_t exp_o;
		int stall_mode;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (inverse_queue.size() == 0) begin
					$error("unexpected word: %h", out_data);
					errors++;
				end else begin
					exp_o = inverse_queue.pop_front();
					words_checked++;
					if (exp_o.singular) singular_seen++;
					if (exp_o.inv_r0c0 == SAT_MAX || exp_o.inv_r0c0 == SAT_MIN) saturated_seen++;
					compare_field("inv_r0c0", exp_o.inv_r0c0, out_data.inv_r0c0);
					compare_field("inv_r0c1", exp_o.inv_r0c1, out_data.inv_r0c1);
					compare_field("inv_r0c2", exp_o.inv_r0c2, out_data.inv_r0c2);
					compare_field("inv_r1c0", exp_o.inv_r1c0, out_data.inv_r1c0);
					compare_field("inv_r1c1", exp_o.inv_r1c1, out_data.inv_r1c1);
					compare_field("inv_r1c2", exp_o.inv_r1c2, out_data.inv_r1c2);
					compare_field("inv_r2c0", exp_o.inv_r2c0, out_data.inv_r2c0);
					compare_field("inv_r2c1", exp_o.inv_r2c1, out_data.inv_r2c1);
					compare_field("inv_r2c2", exp_o.inv_r2c2, out_data.inv_r2c2);
					compare_field("singular", 32'(exp_o.singular), 32'(out_data.singular));
				end
			end
			if ((words_sent / 300) % 3 == 1) stall_mode = 0;
			else stall_mode = 1;
			out_ready <= stall_mode == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog
	initial begin
		idle_cycles = 0;
		timed_out = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("matrix_inverse_3x3_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_matrix(in_t m);
		in_valid <= 1'b1;
		in_data <= m;
		do @(posedge clk); while (!in_ready);
		inverse_queue.push_back(predict_inverse(m));
		words_sent++;
		if ($urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			in_data <= in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (inverse_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [AW-1:0] addr, logic [DAW-1:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_THRESH) threshold = data[TW-1:0];
		@(posedge clk);
	endtask

	function automatic in_t make_matrix(logic signed [15:0] e0, e1, e2, e3, e4, e5, e6, e7, e8);
		return '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
	endfunction

	function automatic logic [15:0] random_elem();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1024)) - 512);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($signed($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic in_t random_matrix();
		in_t m;
		m = in_t'({random_elem(), random_elem(), random_elem(), random_elem(),
			random_elem(), random_elem(), random_elem(), random_elem(), random_elem()});
		case ($urandom_range(0, 9))
			0: begin m.a_r1c0 = m.a_r0c0; m.a_r1c1 = m.a_r0c1; m.a_r1c2 = m.a_r0c2; end
			1: begin m.a_r0c1 = 0; m.a_r0c2 = 0; m.a_r1c0 = 0; m.a_r1c2 = 0;
				m.a_r2c0 = 0; m.a_r2c1 = 0; end
			default: ;
		endcase
		return m;
	endfunction

	task automatic test_directed();
		send_matrix(make_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256));
		send_matrix(make_matrix(512, 0, 0, 0, -256, 0, 0, 0, 128));
		send_matrix('0);
		send_matrix(make_matrix(1, 2, 3, 2, 4, 6, 7, 8, 9));
		send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
		send_matrix(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
		send_matrix(make_matrix(16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF));
		send_matrix(make_matrix(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000));
		send_matrix(make_matrix(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
		send_matrix(make_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
		send_matrix(make_matrix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_matrix(make_matrix(2, 1, 0, 1, 3, 1, 0, 1, 4));
		send_matrix(make_matrix(1000, -3000, 7, 12, 16'h7FFF, -5, 3, 2, 16'h8000));
		end_burst();
		drain();
	endtask

	task automatic test_threshold(logic [DAW-1:0] value, int count);
		write_reg(ADDR_THRESH, value);
		for (int i = 0; i < count; i++) begin
			send_matrix(random_matrix());
			if ($urandom_range(0, 15) == 0) begin
				end_burst();
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		end_burst();
		drain();
	endtask

	task automatic test_unused_register();
		write_reg(ADDR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 10; i++) send_matrix(random_matrix());
		end_burst();
		drain();
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		singular_seen = 0;
		saturated_seen = 0;
		threshold = THRESH_RST;
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		in_valid <= 1'b0; in_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold(64'd0, 400);
		test_threshold(64'h0000_FFFF_FFFF_FFFF, 100);
		test_threshold(64'd1 << 24, 400);
		test_threshold(64'd1 << 40, 300);
		test_threshold(64'h5A5A_A5A5_A5A5_5A5A, 50);
		test_unused_register();
		test_threshold(64'd1, 350);
		$display("sent %0d matrices, checked %0d, %0d singular, %0d saturated corner elements",
			words_sent, words_checked, singular_seen, saturated_seen);
		$display("thresholds swept from zero to full scale, unused register address written");
		if (errors == 0)
			$display("matrix_inverse_3x3_tb: PASS");
		else
			$display("matrix_inverse_3x3_tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mi3_pkg.sv
rtl/mi3_cof.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3.sv
bench/matrix_inverse_3x3_tb.sv
